// File: rtl/crhq_pkg.sv
// ----------------------------------------------------------------------------
// crhq_pkg
// Shared types and constants for the car rearrangement block: result kinds,
// controller states and the command and status groups between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package crhq_pkg;

  // Fixed widths of the stream fields and of the track count register.
  localparam int CarIdW     = 16;
  localparam int TrackIdxW  = 2;
  localparam int TracksCfgW = 3;

  localparam logic [TracksCfgW-1:0] TracksReset = 3'd4;

  typedef enum logic [1:0] {
    EV_PLACED  = 2'd0,
    EV_MOVED   = 2'd1,
    EV_NO_FIT  = 2'd2,
    EV_IGNORED = 2'd3
  } event_kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_REJECT,
    ST_SEARCH,
    ST_DECIDE,
    ST_FAIL,
    ST_DRAIN_RD,
    ST_DRAIN_CMP,
    ST_FLUSH
  } ctl_state_t;

  typedef struct packed {
    logic        accept;
    logic        scan_step;
    logic        place;
    logic        drain_next;
    logic        move;
    logic        emit_direct;
    event_kind_t direct_kind;
    logic        set_halt;
    logic        flush;
  } ctl_cmd_t;

  typedef struct packed {
    logic halted;
    logic scan_last;
    logic no_fit;
    logic occ_zero;
    logic head_match;
    logic can_emit;
  } dp_status_t;

endpackage

// File: rtl/crhq_dp.sv
// ----------------------------------------------------------------------------
// crhq_dp
// Datapath: track store memory, per-track head, count and tail registers,
// the search and drain scan registers, a pending result and the output
// register.
// ----------------------------------------------------------------------------
module crhq_dp import crhq_pkg::*; #(
  parameter int NUM_TRACKS  = 4,
  parameter int TRACK_DEPTH = 15,
  parameter int CAR_BITS    = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [CarIdW-1:0]     in_car,
  input  logic                  in_start_new,
  input  logic                  cfg_we,
  input  logic [TracksCfgW-1:0] cfg_data,
  input  ctl_cmd_t              cmd,
  output dp_status_t            stat,
  output logic                  out_valid,
  input  logic                  out_ready,
  output event_kind_t           out_kind,
  output logic [CarIdW-1:0]     out_car,
  output logic [TrackIdxW-1:0]  out_trk,
  output logic                  out_last
);

  localparam int TW    = (NUM_TRACKS > 1) ? $clog2(NUM_TRACKS) : 1;
  localparam int SW    = (TRACK_DEPTH > 1) ? $clog2(TRACK_DEPTH) : 1;
  localparam int SumW  = SW + 1;
  localparam int OW    = $clog2(TRACK_DEPTH + 1);
  localparam int Depth = NUM_TRACKS * TRACK_DEPTH;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;

  logic [CAR_BITS-1:0]   mem [Depth];
  logic [CAR_BITS-1:0]   rd_data;

  logic [TracksCfgW-1:0] cfg_reg;
  logic                  halted;
  logic [CAR_BITS-1:0]   last_car;
  logic [SW-1:0]         head [NUM_TRACKS];
  logic [OW-1:0]         occ  [NUM_TRACKS];
  logic [CAR_BITS-1:0]   tail [NUM_TRACKS];

  logic [CAR_BITS-1:0]   car_reg;
  logic [TW-1:0]         scan_t;
  logic                  have_tail;
  logic                  have_empty;
  logic [CAR_BITS-1:0]   best;
  logic [TW-1:0]         pick_t;
  logic [OW-1:0]         pick_occ;
  logic [SW-1:0]         pick_head;
  logic [TW-1:0]         empty_t;
  logic [SW-1:0]         empty_head;

  event_kind_t           pend_kind;
  logic [CAR_BITS-1:0]   pend_car;
  logic [TW-1:0]         pend_trk;

  logic [CAR_BITS+CarIdW-1:0] car_in_ext;
  logic [CAR_BITS-1:0]        car_in;
  logic [CAR_BITS+CarIdW-1:0] car_reg_ext;
  logic [CAR_BITS+CarIdW-1:0] pend_car_ext;
  logic [TW+TrackIdxW-1:0]    pend_trk_ext;
  logic [4:0]                 cfg_ext;
  logic [4:0]                 used_m1_ext;
  logic [TW-1:0]              used_m1;
  logic [SW-1:0]              cur_head;
  logic [OW-1:0]              cur_occ;
  logic [CAR_BITS-1:0]        cur_tail;
  logic [SW-1:0]              cur_head_inc;
  logic [AW-1:0]              rd_addr;
  logic [TW-1:0]              ch_t;
  logic [OW-1:0]              ch_occ;
  logic [SW-1:0]              ch_head;
  logic [SumW-1:0]            wr_sum;
  logic [SumW-1:0]            wr_slot;
  logic [AW-1:0]              wr_addr;
  logic [CAR_BITS-1:0]        want;

  // Cars are masked to CAR_BITS on the way in and cut to the port width on the way out.
  assign car_in_ext   = {{CAR_BITS{1'b0}}, in_car};
  assign car_in       = car_in_ext[CAR_BITS-1:0];
  assign car_reg_ext  = {{CarIdW{1'b0}}, car_reg};
  assign pend_car_ext = {{CarIdW{1'b0}}, pend_car};
  assign pend_trk_ext = {{TrackIdxW{1'b0}}, pend_trk};

  // A track count of zero means one track, and a count above the track total means all.
  always_comb begin
    cfg_ext = 5'(cfg_reg);
    if (cfg_reg == '0) begin
      used_m1_ext = '0;
    end else if (cfg_ext > 5'(NUM_TRACKS)) begin
      used_m1_ext = 5'(NUM_TRACKS - 1);
    end else begin
      used_m1_ext = cfg_ext - 5'd1;
    end
    used_m1 = used_m1_ext[TW-1:0];
  end

  assign cur_head     = head[scan_t];
  assign cur_occ      = occ[scan_t];
  assign cur_tail     = tail[scan_t];
  assign cur_head_inc = (cur_head == SW'(TRACK_DEPTH - 1)) ? '0 : cur_head + SW'(1);
  assign rd_addr      = AW'(scan_t * TRACK_DEPTH) + AW'(cur_head);

  assign ch_t    = have_tail ? pick_t : empty_t;
  assign ch_occ  = have_tail ? pick_occ : '0;
  assign ch_head = have_tail ? pick_head : empty_head;

  // The tail slot wraps at most once, so one compare and subtract does the modulo.
  always_comb begin
    wr_sum = SumW'(ch_head) + SumW'(ch_occ);
    if (wr_sum >= SumW'(TRACK_DEPTH)) begin
      wr_slot = wr_sum - SumW'(TRACK_DEPTH);
    end else begin
      wr_slot = wr_sum;
    end
    wr_addr = AW'(ch_t * TRACK_DEPTH) + AW'(wr_slot);
  end

  assign want = last_car + CAR_BITS'(1);

  assign stat.halted     = halted;
  assign stat.scan_last  = (scan_t == used_m1);
  assign stat.no_fit     = (!have_tail && !have_empty) || (ch_occ >= OW'(TRACK_DEPTH));
  assign stat.occ_zero   = (cur_occ == '0);
  assign stat.head_match = (rd_data == want);
  assign stat.can_emit   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.place) begin
      mem[wr_addr] <= car_reg;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_reg   <= TracksReset;
      halted    <= 1'b0;
      last_car  <= '0;
      out_valid <= 1'b0;
      for (int t = 0; t < NUM_TRACKS; t++) begin
        head[t] <= '0;
        occ[t]  <= '0;
      end
    end else begin
      if (cfg_we) begin
        cfg_reg <= cfg_data;
      end
      if (cmd.accept && in_start_new) begin
        halted   <= 1'b0;
        last_car <= '0;
        for (int t = 0; t < NUM_TRACKS; t++) begin
          head[t] <= '0;
          occ[t]  <= '0;
        end
      end
      if (cmd.set_halt) begin
        halted <= 1'b1;
      end
      if (cmd.place) begin
        occ[ch_t] <= ch_occ + OW'(1);
      end
      if (cmd.move) begin
        head[scan_t] <= cur_head_inc;
        occ[scan_t]  <= cur_occ - OW'(1);
        last_car     <= want;
      end
      if (cmd.emit_direct || cmd.move || cmd.flush) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      car_reg    <= car_in;
      scan_t     <= '0;
      have_tail  <= 1'b0;
      have_empty <= 1'b0;
      pick_t     <= '0;
      empty_t    <= '0;
    end
    if (cmd.scan_step) begin
      if (cur_occ == '0) begin
        if (!have_empty) begin
          have_empty <= 1'b1;
          empty_t    <= scan_t;
          empty_head <= cur_head;
        end
      end else if (cur_tail < car_reg && (!have_tail || cur_tail > best)) begin
        have_tail <= 1'b1;
        best      <= cur_tail;
        pick_t    <= scan_t;
        pick_occ  <= cur_occ;
        pick_head <= cur_head;
      end
      scan_t <= scan_t + TW'(1);
    end
    if (cmd.drain_next) begin
      scan_t <= scan_t + TW'(1);
    end
    if (cmd.place) begin
      tail[ch_t] <= car_reg;
      pend_kind  <= EV_PLACED;
      pend_car   <= car_reg;
      pend_trk   <= ch_t;
      scan_t     <= '0;
    end
    if (cmd.move) begin
      out_kind  <= pend_kind;
      out_car   <= pend_car_ext[CarIdW-1:0];
      out_trk   <= pend_trk_ext[TrackIdxW-1:0];
      out_last  <= 1'b0;
      pend_kind <= EV_MOVED;
      pend_car  <= want;
      pend_trk  <= scan_t;
      scan_t    <= '0;
    end
    if (cmd.flush) begin
      out_kind <= pend_kind;
      out_car  <= pend_car_ext[CarIdW-1:0];
      out_trk  <= pend_trk_ext[TrackIdxW-1:0];
      out_last <= 1'b1;
    end
    if (cmd.emit_direct) begin
      out_kind <= cmd.direct_kind;
      out_car  <= car_reg_ext[CarIdW-1:0];
      out_trk  <= '0;
      out_last <= 1'b1;
    end
  end

endmodule

// File: rtl/crhq_ctrl.sv
// ----------------------------------------------------------------------------
// crhq_ctrl
// Controller: sequences the acceptance of a car, the track search, the
// placement and the drain of track heads to the exit.
// ----------------------------------------------------------------------------
module crhq_ctrl import crhq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t stat,
  output ctl_cmd_t   cmd
);

  ctl_state_t state;
  ctl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_next = stat.halted ? ST_REJECT : ST_SEARCH;
      end
      ST_REJECT: begin
        if (stat.can_emit) begin
          cmd.emit_direct = 1'b1;
          cmd.direct_kind = EV_IGNORED;
          state_next      = ST_IDLE;
        end
      end
      ST_SEARCH: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (stat.no_fit) begin
          state_next = ST_FAIL;
        end else begin
          cmd.place  = 1'b1;
          state_next = ST_DRAIN_RD;
        end
      end
      ST_FAIL: begin
        if (stat.can_emit) begin
          cmd.emit_direct = 1'b1;
          cmd.direct_kind = EV_NO_FIT;
          cmd.set_halt    = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      ST_DRAIN_RD: begin
        // Empty tracks are skipped without a memory read.
        if (!stat.occ_zero) begin
          state_next = ST_DRAIN_CMP;
        end else if (stat.scan_last) begin
          state_next = ST_FLUSH;
        end else begin
          cmd.drain_next = 1'b1;
        end
      end
      ST_DRAIN_CMP: begin
        if (stat.head_match) begin
          // The move pushes the held result out, so it waits for the output register.
          if (stat.can_emit) begin
            cmd.move   = 1'b1;
            state_next = ST_DRAIN_RD;
          end
        end else if (stat.scan_last) begin
          state_next = ST_FLUSH;
        end else begin
          cmd.drain_next = 1'b1;
          state_next     = ST_DRAIN_RD;
        end
      end
      ST_FLUSH: begin
        if (stat.can_emit) begin
          cmd.flush  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/car_reorder_with_holding_queues_top.sv
// ----------------------------------------------------------------------------
// car_reorder_with_holding_queues_top
// Cars arrive one per input beat and are rearranged through FIFO holding
// tracks; each placement, move to the exit, ignored car and no-fit is a beat.
// ----------------------------------------------------------------------------
// One car is handled at a time. A car is accepted and checked, then the
// tails of the tracks in use are searched one track at a time and the car
// is placed. The drain then visits the tracks in use from track 0: an
// empty track is skipped, an occupied one gets a store read and a head
// compare, and every move to the exit restarts the visit from track 0; a
// final step hands over the last result. The store is one memory of
// NUM_TRACKS * TRACK_DEPTH cars with a single write and a single registered
// read, and needs no clearing after reset. Result beats leave through an
// output register, so a stalled output only holds the controller when a
// further result is ready to go.
module car_reorder_with_holding_queues_top import crhq_pkg::*; #(
  parameter int NUM_TRACKS  = 4,
  parameter int TRACK_DEPTH = 15,
  parameter int CAR_BITS    = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [15:0]           s_tdata,   // [15:0] car_number
  input  logic                  s_tuser,   // [0] start_new
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [23:0]           m_tdata,   // [15:0] car_id, [17:16] track_index, zeros above
  output logic [1:0]            m_tuser,   // [1:0] event_kind
  output logic                  m_tlast,   // last_of_run
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [TracksCfgW-1:0] cfg_data   // tracks_in_use
);

  ctl_cmd_t               cmd;
  dp_status_t             stat;
  event_kind_t            out_kind;
  logic [CarIdW-1:0]      out_car;
  logic [TrackIdxW-1:0]   out_trk;

  assign cfg_ready = 1'b1;
  assign m_tdata   = {6'b0, out_trk, out_car};
  assign m_tuser   = out_kind;

  crhq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  crhq_dp #(
    .NUM_TRACKS  (NUM_TRACKS),
    .TRACK_DEPTH (TRACK_DEPTH),
    .CAR_BITS    (CAR_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .in_car       (s_tdata),
    .in_start_new (s_tuser),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_kind     (out_kind),
    .out_car      (out_car),
    .out_trk      (out_trk),
    .out_last     (m_tlast)
  );

endmodule
